// File: rtl/ordered_array_list_core_macros.svh
// assertion macros shared by the ordered array list rtl
// the including module must have signals named clk and arst_n
`ifndef ORDERED_ARRAY_LIST_CORE_MACROS_SVH
`define ORDERED_ARRAY_LIST_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define OAL_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("oal assertion failed");
// consequent holds in the same cycle
`define OAL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oal assertion failed");
// consequent holds in the next cycle
`define OAL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oal assertion failed");
`else
`define OAL_ASSERT(lbl, cond)
`define OAL_ASSERT_IMP(lbl, ante, cons)
`define OAL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/oal_pkg.sv
// shared codes and control types of the ordered array list
// no dependencies
`default_nettype none
package oal_pkg;

	// request kinds
	localparam logic [2:0] RQ_INSERT   = 3'd0;
	localparam logic [2:0] RQ_DELETE   = 3'd1;
	localparam logic [2:0] RQ_SORTED   = 3'd2;
	localparam logic [2:0] RQ_LOCATE   = 3'd3;
	localparam logic [2:0] RQ_RETRIEVE = 3'd4;
	localparam logic [2:0] RQ_CLEAR    = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// pointer operations
	localparam logic [2:0] PTR_HOLD = 3'd0;
	localparam logic [2:0] PTR_LAST = 3'd1;
	localparam logic [2:0] PTR_POS1 = 3'd2;
	localparam logic [2:0] PTR_ZERO = 3'd3;
	localparam logic [2:0] PTR_INC  = 3'd4;
	localparam logic [2:0] PTR_DEC  = 3'd5;

	// target slot operations
	localparam logic [1:0] TGT_HOLD = 2'd0;
	localparam logic [1:0] TGT_POS  = 2'd1;
	localparam logic [1:0] TGT_LAG  = 2'd2;
	localparam logic [1:0] TGT_CNT  = 2'd3;

	// entry count operations
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	// write address selects
	localparam logic [1:0] WA_TGT    = 2'd0;
	localparam logic [1:0] WA_LAG_UP = 2'd1;
	localparam logic [1:0] WA_LAG_DN = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic       load_req;
		logic       rd_pos;
		logic       wr_en;
		logic [1:0] wa_sel;
		logic [2:0] ptr_op;
		logic [1:0] tgt_op;
		logic [1:0] cnt_op;
		logic       st_ld;
		logic [1:0] st_code;
		logic       val_ld;
		logic       idx_use;
		logic       out_ld;
	} oal_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] kind;
		logic       pos_gt_cnt;
		logic       pos_eq_cnt;
		logic       pos_last;
		logic       full;
		logic       empty;
		logic       ptr_at_tgt;
		logic       ptr_at_last;
		logic       lag_at_last;
		logic       hit;
	} oal_sts_t;

endpackage
`default_nettype wire

// File: rtl/oal_if.sv
// request and result channel interfaces of the ordered array list
// no dependencies
`default_nettype none
interface oal_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        req_type;
	logic [4:0]        position;
	logic signed [31:0] data;

	modport source(output valid, output req_type, output position, output data, input ready);
	modport sink(input valid, input req_type, input position, input data, output ready);
endinterface

interface oal_rsp_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic signed [31:0] value;
	logic [3:0]        index;
	logic [4:0]        count_after;

	modport source(output valid, output status, output value, output index,
		output count_after, input ready);
	modport sink(input valid, input status, input value, input index,
		input count_after, output ready);
endinterface
`default_nettype wire

// File: rtl/ordered_array_list_core.sv
// top level of the ordered array list: controller, datapath and channel hookup
// depends on oal_pkg, oal_if, oal_ctrl and oal_dpath
//
// Fixed-capacity list of signed 32-bit entries kept in one ram with a single
// write and a single registered read port. One request is worked on at a time
// and gives one result. Insert, delete and sorted insert are bounded by moving
// one entry per cycle through the ram port pair; locate and the sorted
// placement search read one entry per cycle. A new request is taken while the
// previous result still waits in the output register. The ram contents are not
// cleared at reset; only values of entries below the count are ever used.
`default_nettype none
module ordered_array_list_core #(
	parameter int CAPACITY = 16
) (
	input logic       clk,
	input logic       arst_n,
	oal_req_if.sink   req,
	oal_rsp_if.source rsp
);
	import oal_pkg::*;

	oal_cmd_t cmd;
	oal_sts_t sts;

	// sequencing
	oal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	oal_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req.req_type),
		.position   (req.position),
		.data       (req.data),
		.cmd        (cmd),
		.sts        (sts),
		.status     (rsp.status),
		.value      (rsp.value),
		.index      (rsp.index),
		.count_after(rsp.count_after)
	);

endmodule
`default_nettype wire

// File: rtl/oal_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module oal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/oal_dpath.sv
// datapath of the ordered array list: entry ram, count, pointers, result registers
// depends on oal_pkg, oal_ram and the assertion macro header
`default_nettype none
`include "ordered_array_list_core_macros.svh"
module oal_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         req_type,
	input  logic [4:0]         position,
	input  logic signed [31:0] data,
	input  oal_pkg::oal_cmd_t  cmd,
	output oal_pkg::oal_sts_t  sts,
	output logic [1:0]         status,
	output logic signed [31:0] value,
	output logic [3:0]         index,
	output logic [4:0]         count_after
);
	import oal_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [2:0]         kind_q;
	logic [4:0]         pos_q;
	logic signed [31:0] data_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      lag_q;
	logic [AW-1:0]      tgt_q;
	logic [1:0]         st_q;
	logic signed [31:0] val_q;
	logic               idx_use_q;
	logic [1:0]         out_status_q;
	logic signed [31:0] out_value_q;
	logic [3:0]         out_index_q;
	logic [4:0]         out_count_q;

	logic [EW-1:0]      pos_ext;
	logic [EW-1:0]      cnt_ext;
	logic [CW-1:0]      cnt_m1;
	logic [CW-1:0]      wa_full;
	logic [AW-1:0]      ram_wa;
	logic [AW-1:0]      ram_ra;
	logic signed [31:0] ram_wd;
	logic signed [31:0] ram_rd;

	assign pos_ext = EW'(pos_q);
	assign cnt_ext = EW'(count_q);
	assign cnt_m1  = count_q - CW'(1);

	// ram addressing and write data
	always_comb begin
		case (cmd.wa_sel)
			WA_LAG_UP: wa_full = lag_q + CW'(1);
			WA_LAG_DN: wa_full = lag_q - CW'(1);
			default:   wa_full = CW'(tgt_q);
		endcase
	end
	assign ram_wa = AW'(wa_full);
	assign ram_wd = (cmd.wa_sel == WA_TGT) ? data_q : ram_rd;
	assign ram_ra = cmd.rd_pos ? AW'(pos_ext) : AW'(ptr_q);

	oal_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(ram_ra),
		.rdata(ram_rd)
	);

	// status flags for the controller
	always_comb begin
		sts.kind        = kind_q;
		sts.pos_gt_cnt  = pos_ext > cnt_ext;
		sts.pos_eq_cnt  = pos_ext == cnt_ext;
		sts.pos_last    = (pos_ext + EW'(1)) == cnt_ext;
		sts.full        = count_q == CAP_C;
		sts.empty       = count_q == '0;
		sts.ptr_at_tgt  = ptr_q == CW'(tgt_q);
		sts.ptr_at_last = ptr_q == cnt_m1;
		sts.lag_at_last = lag_q == cnt_m1;
		// locate wants equality, sorted insert stops at the first entry not below data
		sts.hit         = (kind_q == RQ_LOCATE) ? (ram_rd == data_q) : !(ram_rd < data_q);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= cnt_m1;
				CNT_CLR: count_q <= '0;
				default: count_q <= count_q;
			endcase
		end
	end

	// request capture, pointers and result registers
	always_ff @(posedge clk) begin
		lag_q <= ptr_q;
		if (cmd.load_req) begin
			kind_q    <= req_type;
			pos_q     <= position;
			data_q    <= data;
			st_q      <= ST_OK;
			val_q     <= '0;
			idx_use_q <= 1'b0;
		end
		case (cmd.ptr_op)
			PTR_LAST: ptr_q <= cnt_m1;
			PTR_POS1: ptr_q <= CW'(pos_ext + EW'(1));
			PTR_ZERO: ptr_q <= '0;
			PTR_INC:  ptr_q <= ptr_q + CW'(1);
			PTR_DEC:  ptr_q <= ptr_q - CW'(1);
			default:  ptr_q <= ptr_q;
		endcase
		case (cmd.tgt_op)
			TGT_POS: tgt_q <= AW'(pos_ext);
			TGT_LAG: tgt_q <= AW'(lag_q);
			TGT_CNT: tgt_q <= AW'(count_q);
			default: tgt_q <= tgt_q;
		endcase
		if (cmd.st_ld) begin
			st_q <= cmd.st_code;
		end
		if (cmd.val_ld) begin
			val_q <= ram_rd;
		end
		if (cmd.idx_use) begin
			idx_use_q <= 1'b1;
		end
		// result register toward the output channel
		if (cmd.out_ld) begin
			out_status_q <= st_q;
			out_value_q  <= val_q;
			out_index_q  <= idx_use_q ? 4'(tgt_q) : 4'd0;
			out_count_q  <= 5'(count_q);
		end
	end

	assign status      = out_status_q;
	assign value       = out_value_q;
	assign index       = out_index_q;
	assign count_after = out_count_q;

	`OAL_ASSERT(a_count_cap, count_q <= CAP_C)
	`OAL_ASSERT_IMP(a_inc_room, cmd.cnt_op == CNT_INC, count_q < CAP_C)
	`OAL_ASSERT_IMP(a_dec_held, cmd.cnt_op == CNT_DEC, count_q != '0)
	`OAL_ASSERT_IMP(a_wr_range, cmd.wr_en, wa_full < CAP_C)

endmodule
`default_nettype wire

// File: rtl/oal_ctrl.sv
// controller state machine of the ordered array list
// depends on oal_pkg and the assertion macro header
`default_nettype none
`include "ordered_array_list_core_macros.svh"
module oal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  oal_pkg::oal_sts_t sts,
	output oal_pkg::oal_cmd_t cmd
);
	import oal_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_SCN0  = 4'd2;
	localparam logic [3:0] S_SCN   = 4'd3;
	localparam logic [3:0] S_SHU0  = 4'd4;
	localparam logic [3:0] S_SHU   = 4'd5;
	localparam logic [3:0] S_SHUW  = 4'd6;
	localparam logic [3:0] S_PLACE = 4'd7;
	localparam logic [3:0] S_RDV   = 4'd8;
	localparam logic [3:0] S_DLV   = 4'd9;
	localparam logic [3:0] S_SHD0  = 4'd10;
	localparam logic [3:0] S_SHD   = 4'd11;
	localparam logic [3:0] S_SHDW  = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (sts.kind)
					RQ_INSERT: begin
						if (sts.pos_gt_cnt) begin
							cmd.st_ld   = 1'b1;
							cmd.st_code = ST_BADPOS;
						end else if (sts.full) begin
							cmd.st_ld   = 1'b1;
							cmd.st_code = ST_FULL;
						end else if (sts.pos_eq_cnt) begin
							cmd.tgt_op = TGT_POS;
							state_d    = S_PLACE;
						end else begin
							cmd.tgt_op = TGT_POS;
							cmd.ptr_op = PTR_LAST;
							state_d    = S_SHU0;
						end
					end
					RQ_DELETE: begin
						if (sts.pos_gt_cnt || sts.pos_eq_cnt) begin
							cmd.st_ld   = 1'b1;
							cmd.st_code = ST_BADPOS;
						end else begin
							cmd.rd_pos = 1'b1;
							state_d    = S_DLV;
						end
					end
					RQ_SORTED: begin
						if (sts.full) begin
							cmd.st_ld   = 1'b1;
							cmd.st_code = ST_FULL;
						end else if (sts.empty) begin
							cmd.tgt_op = TGT_CNT;
							state_d    = S_PLACE;
						end else begin
							cmd.ptr_op = PTR_ZERO;
							state_d    = S_SCN0;
						end
					end
					RQ_LOCATE: begin
						if (sts.empty) begin
							cmd.st_ld   = 1'b1;
							cmd.st_code = ST_NOTFOUND;
						end else begin
							cmd.ptr_op = PTR_ZERO;
							state_d    = S_SCN0;
						end
					end
					RQ_RETRIEVE: begin
						if (sts.pos_gt_cnt || sts.pos_eq_cnt) begin
							cmd.st_ld   = 1'b1;
							cmd.st_code = ST_BADPOS;
						end else begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RDV;
						end
					end
					RQ_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
					end
					default: begin
					end
				endcase
			end
			// first scan read
			S_SCN0: begin
				cmd.ptr_op = PTR_INC;
				state_d    = S_SCN;
			end
			// compare the entry read last cycle while reading the next one
			S_SCN: begin
				if (sts.hit) begin
					cmd.tgt_op = TGT_LAG;
					if (sts.kind == RQ_LOCATE) begin
						cmd.idx_use = 1'b1;
						state_d     = S_DONE;
					end else begin
						cmd.ptr_op = PTR_LAST;
						state_d    = S_SHU0;
					end
				end else if (sts.lag_at_last) begin
					if (sts.kind == RQ_LOCATE) begin
						cmd.st_ld   = 1'b1;
						cmd.st_code = ST_NOTFOUND;
						state_d     = S_DONE;
					end else begin
						cmd.tgt_op = TGT_CNT;
						state_d    = S_PLACE;
					end
				end else begin
					cmd.ptr_op = PTR_INC;
				end
			end
			// shift up: read entry, write it one slot higher next cycle
			S_SHU0: begin
				cmd.ptr_op = PTR_DEC;
				state_d    = sts.ptr_at_tgt ? S_SHUW : S_SHU;
			end
			S_SHU: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_LAG_UP;
				cmd.ptr_op = PTR_DEC;
				if (sts.ptr_at_tgt) begin
					state_d = S_SHUW;
				end
			end
			S_SHUW: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_LAG_UP;
				state_d    = S_PLACE;
			end
			S_PLACE: begin
				cmd.wr_en   = 1'b1;
				cmd.wa_sel  = WA_TGT;
				cmd.cnt_op  = CNT_INC;
				cmd.idx_use = sts.kind == RQ_SORTED;
				state_d     = S_DONE;
			end
			S_RDV: begin
				cmd.val_ld = 1'b1;
				state_d    = S_DONE;
			end
			S_DLV: begin
				cmd.val_ld = 1'b1;
				if (sts.pos_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_DONE;
				end else begin
					cmd.ptr_op = PTR_POS1;
					state_d    = S_SHD0;
				end
			end
			// shift down: read entry, write it one slot lower next cycle
			S_SHD0: begin
				cmd.ptr_op = PTR_INC;
				state_d    = sts.ptr_at_last ? S_SHDW : S_SHD;
			end
			S_SHD: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_LAG_DN;
				cmd.ptr_op = PTR_INC;
				if (sts.ptr_at_last) begin
					state_d = S_SHDW;
				end
			end
			S_SHDW: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_LAG_DN;
				cmd.cnt_op = CNT_DEC;
				state_d    = S_DONE;
			end
			// hand the result to the output register once it is free
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`OAL_ASSERT_NXT(a_accept_disp, in_valid && in_ready, state_q == S_DISP)
	`OAL_ASSERT_IMP(a_out_slot, cmd.out_ld, !out_valid_q || out_ready)
	`OAL_ASSERT_IMP(a_idle_quiet, state_q == S_IDLE, !cmd.wr_en && cmd.cnt_op == CNT_HOLD)

endmodule
`default_nettype wire

// File: tb/ordered_array_list_core_tb.sv
// self-checking testbench of ordered_array_list_core: directed and random requests
// against an in-bench list predictor, with bursty requests and a stalling result sink
// depends on oal_pkg, oal_if and the ordered_array_list_core rtl
`default_nettype none
module ordered_array_list_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oal_pkg::*;

	localparam int CAPACITY = 16;
	localparam int RANDOM_REQUESTS = 600;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam longint LIMIT_NS = 1_000_000;

	// request kinds the block takes and ignores
	localparam logic [2:0] RQ_SPARE6 = 3'd6;
	localparam logic [2:0] RQ_SPARE7 = 3'd7;

	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic [3:0]         index;
		logic [4:0]         count_after;
	} list_result_t;

	// list predictor and store of expected results
	class list_scoreboard;
		logic signed [31:0] slots [CAPACITY];
		int held;
		list_result_t expected [$];
		int noted;
		int checked;
		int mismatches;
		int full_rejects;
		int locate_hits;

		function new();
			held = 0;
			noted = 0;
			checked = 0;
			mismatches = 0;
			full_rejects = 0;
			locate_hits = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// shift entries at and above slot up by one and put the value there
		function void open_slot(int slot, logic signed [31:0] din);
			int i;
			for (i = held; i > slot; i--)
				slots[i] = slots[i - 1];
			slots[slot] = din;
			held++;
		endfunction

		// accepted request: update the list and queue the result it gives
		function void note_request(logic [2:0] kind, logic [4:0] pos, logic signed [31:0] din);
			list_result_t r;
			int i;
			r.status = ST_OK;
			r.value = '0;
			r.index = '0;
			noted++;
			case (kind)
				RQ_INSERT: begin
					if (pos > held)
						r.status = ST_BADPOS;
					else if (held >= CAPACITY)
						r.status = ST_FULL;
					else
						open_slot(pos, din);
				end
				RQ_DELETE: begin
					if (pos >= held) begin
						r.status = ST_BADPOS;
					end else begin
						r.value = slots[pos];
						for (i = pos; i + 1 < held; i++)
							slots[i] = slots[i + 1];
						held--;
					end
				end
				RQ_SORTED: begin
					if (held >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						i = 0;
						while (i < held && slots[i] < din)
							i++;
						open_slot(i, din);
						r.index = i[3:0];
					end
				end
				RQ_LOCATE: begin
					r.status = ST_NOTFOUND;
					for (i = 0; i < held; i++) begin
						if (slots[i] == din) begin
							r.status = ST_OK;
							r.index = i[3:0];
							locate_hits++;
							break;
						end
					end
				end
				RQ_RETRIEVE: begin
					if (pos >= held)
						r.status = ST_BADPOS;
					else
						r.value = slots[pos];
				end
				RQ_CLEAR: held = 0;
				default: ;
			endcase
			if (r.status == ST_FULL)
				full_rejects++;
			r.count_after = held[4:0];
			expected.push_back(r);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		endfunction

		// accepted result: compare with the oldest expectation
		function void check_result(logic [1:0] st, logic signed [31:0] val, logic [3:0] idx,
				logic [4:0] cnt);
			list_result_t e;
			if (expected.size() == 0) begin
				flag("result with nothing expected", '0, '0);
				return;
			end
			e = expected.pop_front();
			checked++;
			if (st !== e.status)
				flag("status", 32'(e.status), 32'(st));
			if (val !== e.value)
				flag("value", e.value, val);
			if (idx !== e.index)
				flag("index", 32'(e.index), 32'(idx));
			if (cnt !== e.count_after)
				flag("count_after", 32'(e.count_after), 32'(cnt));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int burst_left;
	list_scoreboard sb = new();

	oal_req_if req_ch();
	oal_rsp_if rsp_ch();

	ordered_array_list_core #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// hard time limit
	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d results still expected", sb.pending());
		$display("== FAIL ==");
		$finish;
	end

	// watch both channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.status, rsp_ch.value, rsp_ch.index, rsp_ch.count_after);
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.req_type, req_ch.position, req_ch.data);
		end
	end

	// random data word, biased toward extremes and small values
	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return $signed($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// offer one request and wait until it is taken, then pace the next one
	task automatic send_request(input logic [2:0] kind, input logic [4:0] pos,
			input logic signed [31:0] din);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.position <= pos;
		req_ch.data <= din;
		do @(posedge clk); while (!req_ch.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 60);
		end
	endtask

	// result sink: stall patterns, plus one long hold-off while requests keep coming
	initial begin : rsp_sink
		int mode;
		int span;
		int i;
		bit long_hold_done;
		rsp_ch.ready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!long_hold_done && sb.noted >= 200) begin
				long_hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			for (i = 0; i < span; i++) begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= (i % 3 == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// reset, directed requests, random requests, drain and verdict
	initial begin : req_source
		int n;
		int i;
		int roll;
		int cur;
		bit grow;
		logic [2:0] kind;
		logic [4:0] pos;
		logic signed [31:0] din;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = RQ_INSERT;
		req_ch.position = '0;
		req_ch.data = '0;
		burst_left = 4;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list errors
		send_request(RQ_RETRIEVE, 5'd0, 32'sd0);
		send_request(RQ_DELETE, 5'd31, 32'sd0);
		send_request(RQ_LOCATE, 5'd0, 32'sd0);
		send_request(RQ_INSERT, 5'd1, 32'sd5);
		// positional inserts at front, back and with extreme values
		send_request(RQ_INSERT, 5'd0, WORD_MAX);
		send_request(RQ_INSERT, 5'd0, WORD_MIN);
		send_request(RQ_INSERT, 5'd2, 32'sd0);
		// sorted placement, equal value goes before its match
		send_request(RQ_SORTED, 5'd31, -32'sd1);
		send_request(RQ_SORTED, 5'd0, WORD_MAX);
		send_request(RQ_LOCATE, 5'd9, WORD_MAX);
		send_request(RQ_RETRIEVE, 5'd31, 32'sd0);
		// ignored request kinds
		send_request(RQ_SPARE6, 5'd3, $urandom);
		send_request(RQ_SPARE7, 5'd0, $urandom);
		// fill to capacity
		for (i = 0; i < CAPACITY - 5; i++)
			send_request(RQ_SORTED, 5'($urandom_range(0, 31)), rand_word());
		// full list: position check wins over full check
		send_request(RQ_INSERT, 5'd17, 32'sd1);
		send_request(RQ_INSERT, 5'd3, 32'sd1);
		send_request(RQ_SORTED, 5'd0, 32'sd1);
		send_request(RQ_DELETE, 5'd15, 32'sd0);
		send_request(RQ_DELETE, 5'd0, 32'sd0);
		send_request(RQ_RETRIEVE, 5'd0, 32'sd0);
		send_request(RQ_CLEAR, 5'd0, 32'sd0);
		send_request(RQ_RETRIEVE, 5'd0, 32'sd0);

		// random requests, alternating growing and shrinking phases
		n = 0;
		while (n < RANDOM_REQUESTS) begin
			grow = ((n / 80) % 2 == 0);
			cur = sb.held;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				kind = RQ_CLEAR;
			else if (roll < 4)
				kind = $urandom_range(0, 1) ? RQ_SPARE6 : RQ_SPARE7;
			else if (roll < (grow ? 40 : 20))
				kind = RQ_INSERT;
			else if (roll < (grow ? 60 : 26))
				kind = RQ_SORTED;
			else if (roll < (grow ? 70 : 62))
				kind = RQ_DELETE;
			else if (roll < 85)
				kind = RQ_LOCATE;
			else
				kind = RQ_RETRIEVE;

			// mostly legal positions, some anywhere in the field
			if ($urandom_range(0, 99) < 85) begin
				if (kind == RQ_INSERT)
					pos = 5'($urandom_range(0, cur));
				else
					pos = (cur > 0) ? 5'($urandom_range(0, cur - 1)) : 5'd0;
			end else begin
				pos = 5'($urandom_range(0, 31));
			end

			// locate mostly looks for a value that is held
			if (kind == RQ_LOCATE && cur > 0 && $urandom_range(0, 99) < 70)
				din = sb.slots[$urandom_range(0, cur - 1)];
			else
				din = rand_word();

			send_request(kind, pos, din);
			if (kind != RQ_SPARE6 && kind != RQ_SPARE7)
				n++;
		end
		req_ch.valid <= 1'b0;

		// drain outstanding results, then give stray results a chance to show
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests accepted, %0d results checked, %0d mismatches",
			sb.noted, sb.checked, sb.mismatches);
		$display("%0d requests rejected on a full list, %0d locate hits",
			sb.full_rejects, sb.locate_hits);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire
